@@ rtl/rsmfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsmfl_pkg: shared types and constants of the range sensor filter
// Microcode word layout, sequencer status, polynomial coefficient tables.
// ---------------------------------------------------------------------------
package rsmfl_pkg;

  localparam int WINDOW_DEF = 3;
  localparam int COUNT_W    = 16;
  localparam int DIST_W     = 32;
  localparam int ACC_W      = 64;
  localparam int PC_W       = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int K_W        = 3;

  localparam logic [CFG_IDX_W-1:0] REG_LOW_BREAK  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BREAK = 4'd1;

  localparam logic [COUNT_W-1:0] LOW_BREAK_RST  = 16'd506;
  localparam logic [COUNT_W-1:0] HIGH_BREAK_RST = 16'd1253;

  // -1.0 cm in Q12, answered for a bad frame.
  localparam logic [DIST_W-1:0] BAD_DIST = 32'hFFFF_F000;

  typedef enum logic [3:0] {
    OP_NOP,
    OP_IDLE,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_HOLD,
    OP_LOAD,
    OP_MUL_LO,
    OP_MUL_HI,
    OP_ADD,
    OP_ROUND,
    OP_OUT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_ITEM,
    C_BAD,
    C_NOT_FULL,
    C_SCAN_MORE,
    C_MORE,
    C_OUT_BUSY
  } cond_t;

  typedef enum logic [1:0] {
    POLY_CUBIC,
    POLY_QUINTIC,
    POLY_QUAD
  } poly_t;

  typedef struct packed {
    op_t             op;
    cond_t           stall;
    cond_t           jump;
    logic [PC_W-1:0] tgt;
  } ctrl_t;

  typedef struct packed {
    logic no_item;
    logic bad;
    logic not_full;
    logic scan_more;
    logic more;
    logic out_busy;
  } stat_t;

  // Final rounding step of the exact scaled quotient: half up, then sign.
  function automatic logic signed [ACC_W-1:0] coef_round(logic [191:0] q, logic neg);
    logic [ACC_W-1:0] r;
    r = (q[ACC_W-1:0] + 64'd1) >> 1;
    return neg ? -$signed(r) : $signed(r);
  endfunction

  // Each coefficient is the decimal value at 2^(shift+1), rounded to 2^shift.
  localparam logic [191:0] CUB3_Q = (192'd12023716293 << 57) / 192'd100000000000000;
  localparam logic [191:0] CUB2_Q = (192'd17212411657 << 57) / 192'd100000000000;
  localparam logic [191:0] CUB1_Q = (192'd82796230077 << 41) / 192'd1000000000;
  localparam logic [191:0] CUB0_Q = (192'd13500 << 25);

  localparam logic [191:0] QNT5_Q =
    (192'd16303911361 << 85) / 192'd10000000000000000000000;
  localparam logic [191:0] QNT4_Q =
    (192'd79593173713 << 85) / 192'd10000000000000000000;
  localparam logic [191:0] QNT3_Q = (192'd15477757333 << 69) / 192'd1000000000000000;
  localparam logic [191:0] QNT2_Q = (192'd1505512676 << 53) / 192'd100000000000;
  localparam logic [191:0] QNT1_Q = (192'd74075664630 << 37) / 192'd10000000000;
  localparam logic [191:0] QNT0_Q = (192'd1530511 << 21) / 192'd1000;

  localparam logic [191:0] QUD2_Q = (192'd16913557022 << 61) / 192'd1000000000000000;
  localparam logic [191:0] QUD1_Q = (192'd39972587192 << 61) / 192'd1000000000000;
  localparam logic [191:0] QUD0_Q = (192'd34762 << 45) / 192'd10000;

  localparam logic signed [ACC_W-1:0] CUB3 = coef_round(CUB3_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] CUB2 = coef_round(CUB2_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] CUB1 = coef_round(CUB1_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] CUB0 = coef_round(CUB0_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] QNT5 = coef_round(QNT5_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] QNT4 = coef_round(QNT4_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] QNT3 = coef_round(QNT3_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] QNT2 = coef_round(QNT2_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] QNT1 = coef_round(QNT1_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] QNT0 = coef_round(QNT0_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] QUD2 = coef_round(QUD2_Q, 1'b1);
  localparam logic signed [ACC_W-1:0] QUD1 = coef_round(QUD1_Q, 1'b0);
  localparam logic signed [ACC_W-1:0] QUD0 = coef_round(QUD0_Q, 1'b1);

  function automatic logic [K_W-1:0] poly_degree(poly_t p);
    logic [K_W-1:0] d;
    d = 3'd3;
    unique case (p)
      POLY_CUBIC:   d = 3'd3;
      POLY_QUINTIC: d = 3'd5;
      POLY_QUAD:    d = 3'd2;
      default:      d = 3'd3;
    endcase
    return d;
  endfunction

  function automatic logic signed [ACC_W-1:0] coef(poly_t p, logic [K_W-1:0] k);
    logic signed [ACC_W-1:0] c;
    c = '0;
    unique case (p)
      POLY_CUBIC: begin
        unique case (k)
          3'd0:    c = CUB0;
          3'd1:    c = CUB1;
          3'd2:    c = CUB2;
          3'd3:    c = CUB3;
          default: c = '0;
        endcase
      end
      POLY_QUINTIC: begin
        unique case (k)
          3'd0:    c = QNT0;
          3'd1:    c = QNT1;
          3'd2:    c = QNT2;
          3'd3:    c = QNT3;
          3'd4:    c = QNT4;
          3'd5:    c = QNT5;
          default: c = '0;
        endcase
      end
      POLY_QUAD: begin
        unique case (k)
          3'd0:    c = QUD0;
          3'd1:    c = QUD1;
          3'd2:    c = QUD2;
          default: c = '0;
        endcase
      end
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/rsmfl_useq.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsmfl_useq: microcode sequencer
// Step counter and control store; each step may stall on a condition or
// jump on another one, otherwise it advances to the next step.
// ---------------------------------------------------------------------------
module rsmfl_useq (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire rsmfl_pkg::stat_t stat,
  output rsmfl_pkg::ctrl_t    ctrl
);

  localparam logic [rsmfl_pkg::PC_W-1:0] S_IDLE      = 4'd0;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_CHECK     = 4'd1;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_SCAN_INIT = 4'd2;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_SCAN      = 4'd3;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_HOLD      = 4'd4;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_LOAD      = 4'd5;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_MUL_LO    = 4'd6;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_MUL_HI    = 4'd7;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_ADD       = 4'd8;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_ROUND     = 4'd9;
  localparam logic [rsmfl_pkg::PC_W-1:0] S_OUT       = 4'd10;

  function automatic rsmfl_pkg::ctrl_t word(rsmfl_pkg::op_t op, rsmfl_pkg::cond_t stall,
                                            rsmfl_pkg::cond_t jump,
                                            logic [rsmfl_pkg::PC_W-1:0] tgt);
    rsmfl_pkg::ctrl_t w;
    w.op    = op;
    w.stall = stall;
    w.jump  = jump;
    w.tgt   = tgt;
    return w;
  endfunction

  // Control store. Horner loop MUL_LO, MUL_HI, ADD, once per lower coefficient.
  function automatic rsmfl_pkg::ctrl_t program_word(logic [rsmfl_pkg::PC_W-1:0] pc);
    rsmfl_pkg::ctrl_t w;
    w = word(rsmfl_pkg::OP_NOP, rsmfl_pkg::C_NEVER, rsmfl_pkg::C_ALWAYS, S_IDLE);
    unique case (pc)
      S_IDLE:      w = word(rsmfl_pkg::OP_IDLE, rsmfl_pkg::C_NO_ITEM,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_CHECK:     w = word(rsmfl_pkg::OP_NOP, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_BAD, S_OUT);
      S_SCAN_INIT: w = word(rsmfl_pkg::OP_SCAN_INIT, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NOT_FULL, S_LOAD);
      S_SCAN:      w = word(rsmfl_pkg::OP_SCAN, rsmfl_pkg::C_SCAN_MORE,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_HOLD:      w = word(rsmfl_pkg::OP_HOLD, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_LOAD:      w = word(rsmfl_pkg::OP_LOAD, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_MUL_LO:    w = word(rsmfl_pkg::OP_MUL_LO, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_MUL_HI:    w = word(rsmfl_pkg::OP_MUL_HI, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_ADD:       w = word(rsmfl_pkg::OP_ADD, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_MORE, S_MUL_LO);
      S_ROUND:     w = word(rsmfl_pkg::OP_ROUND, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_NEVER, S_IDLE);
      S_OUT:       w = word(rsmfl_pkg::OP_OUT, rsmfl_pkg::C_OUT_BUSY,
                            rsmfl_pkg::C_ALWAYS, S_IDLE);
      default:     w = word(rsmfl_pkg::OP_NOP, rsmfl_pkg::C_NEVER,
                            rsmfl_pkg::C_ALWAYS, S_IDLE);
    endcase
    return w;
  endfunction

  function automatic logic test(rsmfl_pkg::cond_t c, rsmfl_pkg::stat_t s);
    logic t;
    t = 1'b0;
    unique case (c)
      rsmfl_pkg::C_NEVER:     t = 1'b0;
      rsmfl_pkg::C_ALWAYS:    t = 1'b1;
      rsmfl_pkg::C_NO_ITEM:   t = s.no_item;
      rsmfl_pkg::C_BAD:       t = s.bad;
      rsmfl_pkg::C_NOT_FULL:  t = s.not_full;
      rsmfl_pkg::C_SCAN_MORE: t = s.scan_more;
      rsmfl_pkg::C_MORE:      t = s.more;
      rsmfl_pkg::C_OUT_BUSY:  t = s.out_busy;
      default:                t = 1'b0;
    endcase
    return t;
  endfunction

  logic [rsmfl_pkg::PC_W-1:0] pc_r;
  logic [rsmfl_pkg::PC_W-1:0] pc_nxt;

  assign ctrl = program_word(pc_r);

  always_comb begin
    priority if (test(ctrl.stall, stat)) begin
      pc_nxt = pc_r;
    end else if (test(ctrl.jump, stat)) begin
      pc_nxt = ctrl.tgt;
    end else begin
      pc_nxt = pc_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= S_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule
`default_nettype wire

@@ rtl/rsmfl_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// rsmfl_dp: filter and polynomial datapath
// Sample ring with max scan, break registers, one shared 32x16 multiplier,
// 64-bit Horner accumulator, rounding, saturation and the output register.
// ---------------------------------------------------------------------------
module rsmfl_dp #(
  parameter int WINDOW = rsmfl_pkg::WINDOW_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire rsmfl_pkg::ctrl_t                  ctrl,
  output rsmfl_pkg::stat_t                       stat,
  input  wire logic                              cfg_valid,
  output wire logic                              cfg_ready,
  input  wire logic [rsmfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rsmfl_pkg::COUNT_W-1:0]     cfg_data,
  input  wire logic                              in_valid,
  output wire logic                              in_ready,
  input  wire logic [rsmfl_pkg::COUNT_W-1:0]     in_raw_count,
  input  wire logic                              in_frame_ok,
  output wire logic                              out_valid,
  input  wire logic                              out_ready,
  output wire logic signed [rsmfl_pkg::DIST_W-1:0] out_distance_cm,
  output wire logic [rsmfl_pkg::COUNT_W-1:0]     out_filtered_count
);

  localparam int SLOT_W = $clog2(WINDOW);
  localparam int FILL_W = $clog2(WINDOW + 1);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(WINDOW - 1);
  localparam logic [FILL_W-1:0] FULL      = FILL_W'(WINDOW);

  logic [rsmfl_pkg::COUNT_W-1:0] low_break_r, low_break_nxt;
  logic [rsmfl_pkg::COUNT_W-1:0] high_break_r, high_break_nxt;
  logic [rsmfl_pkg::COUNT_W-1:0] ring_r [WINDOW];
  logic [SLOT_W-1:0]             slot_r, slot_nxt;
  logic [FILL_W-1:0]             fill_r, fill_nxt;
  logic [rsmfl_pkg::COUNT_W-1:0] held_max_r, held_max_nxt;
  logic                          out_valid_r, out_valid_nxt;

  logic                          bad_r, bad_nxt;
  logic [SLOT_W-1:0]             scan_idx_r, scan_idx_nxt;
  logic [rsmfl_pkg::COUNT_W-1:0] scan_max_r, scan_max_nxt;
  rsmfl_pkg::poly_t              poly_r, poly_nxt;
  logic [rsmfl_pkg::K_W-1:0]     k_r, k_nxt;
  logic signed [rsmfl_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic [rsmfl_pkg::ACC_W-1:0]   prod_r, prod_nxt;
  logic [rsmfl_pkg::DIST_W-1:0]  out_dist_r, out_dist_nxt;
  logic [rsmfl_pkg::COUNT_W-1:0] out_filt_r, out_filt_nxt;

  logic                          accept;
  logic                          cfg_write;
  logic                          out_busy;
  rsmfl_pkg::poly_t              poly_sel;
  logic [rsmfl_pkg::K_W-1:0]     deg_sel;
  logic [31:0]                   mul_a;
  logic [47:0]                   mul_p;
  logic signed [rsmfl_pkg::ACC_W-1:0] coef_k;
  logic signed [rsmfl_pkg::ACC_W-1:0] sum;
  logic [rsmfl_pkg::DIST_W-1:0]  dist_sat;
  logic [rsmfl_pkg::COUNT_W-1:0] ring_rd;

  assign in_ready  = (ctrl.op == rsmfl_pkg::OP_IDLE);
  assign accept    = in_valid & in_ready;
  assign cfg_ready = 1'b1;
  assign cfg_write = cfg_valid & cfg_ready;
  assign out_busy  = out_valid_r & ~out_ready;

  assign out_valid          = out_valid_r;
  assign out_distance_cm    = $signed(out_dist_r);
  assign out_filtered_count = out_filt_r;

  assign stat.no_item   = ~in_valid;
  assign stat.bad       = bad_r;
  assign stat.not_full  = (fill_r != FULL);
  assign stat.scan_more = (scan_idx_r != LAST_SLOT);
  assign stat.more      = (k_r != '0);
  assign stat.out_busy  = out_busy;

  assign ring_rd = ring_r[scan_idx_r];

  // Branch choice: the cubic test wins over the quadratic test.
  always_comb begin
    priority if (held_max_r < low_break_r) begin
      poly_sel = rsmfl_pkg::POLY_CUBIC;
    end else if (held_max_r > high_break_r) begin
      poly_sel = rsmfl_pkg::POLY_QUAD;
    end else begin
      poly_sel = rsmfl_pkg::POLY_QUINTIC;
    end
  end

  assign deg_sel = rsmfl_pkg::poly_degree(poly_sel);

  // acc * f modulo 2^64 in two passes: low word, then low half of high word * f.
  assign mul_a  = (ctrl.op == rsmfl_pkg::OP_MUL_HI) ? acc_r[63:32] : acc_r[31:0];
  assign mul_p  = {16'd0, mul_a} * {32'd0, held_max_r};
  assign coef_k = rsmfl_pkg::coef(poly_r, k_r);
  assign sum    = $signed(prod_r) + coef_k;

  always_comb begin
    priority if (acc_r > 64'sd2147483647) begin
      dist_sat = 32'h7FFF_FFFF;
    end else if (acc_r < -64'sd2147483648) begin
      dist_sat = 32'h8000_0000;
    end else begin
      dist_sat = acc_r[31:0];
    end
  end

  always_comb begin
    low_break_nxt  = low_break_r;
    high_break_nxt = high_break_r;
    if (cfg_write) begin
      if (cfg_index == rsmfl_pkg::REG_LOW_BREAK) begin
        low_break_nxt = cfg_data;
      end
      if (cfg_index == rsmfl_pkg::REG_HIGH_BREAK) begin
        high_break_nxt = cfg_data;
      end
    end
  end

  always_comb begin
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    held_max_nxt  = held_max_r;
    bad_nxt       = bad_r;
    scan_idx_nxt  = scan_idx_r;
    scan_max_nxt  = scan_max_r;
    poly_nxt      = poly_r;
    k_nxt         = k_r;
    acc_nxt       = acc_r;
    prod_nxt      = prod_r;
    out_dist_nxt  = out_dist_r;
    out_filt_nxt  = out_filt_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    unique case (ctrl.op)
      rsmfl_pkg::OP_IDLE: begin
        if (accept) begin
          bad_nxt = ~in_frame_ok;
          if (in_frame_ok) begin
            slot_nxt = (slot_r == LAST_SLOT) ? '0 : slot_r + 1'b1;
            if (fill_r != FULL) begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
      end
      rsmfl_pkg::OP_SCAN_INIT: begin
        scan_idx_nxt = '0;
        scan_max_nxt = '0;
      end
      rsmfl_pkg::OP_SCAN: begin
        if (ring_rd > scan_max_r) begin
          scan_max_nxt = ring_rd;
        end
        if (scan_idx_r != LAST_SLOT) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
      end
      rsmfl_pkg::OP_HOLD: begin
        held_max_nxt = scan_max_r;
      end
      rsmfl_pkg::OP_LOAD: begin
        poly_nxt = poly_sel;
        acc_nxt  = rsmfl_pkg::coef(poly_sel, deg_sel);
        k_nxt    = deg_sel - 3'd1;
      end
      rsmfl_pkg::OP_MUL_LO: begin
        prod_nxt = {16'd0, mul_p};
      end
      rsmfl_pkg::OP_MUL_HI: begin
        prod_nxt = prod_r + {mul_p[31:0], 32'd0};
      end
      rsmfl_pkg::OP_ADD: begin
        if (k_r != '0) begin
          acc_nxt = sum >>> 16;
          k_nxt   = k_r - 3'd1;
        end else begin
          acc_nxt = sum;
        end
      end
      rsmfl_pkg::OP_ROUND: begin
        // Back to Q12, rounding half up; the shift depends on the branch scale.
        unique case (poly_r)
          rsmfl_pkg::POLY_CUBIC:   acc_nxt = (acc_r + 64'sd2048) >>> 12;
          rsmfl_pkg::POLY_QUINTIC: acc_nxt = (acc_r + 64'sd128) >>> 8;
          rsmfl_pkg::POLY_QUAD:    acc_nxt = (acc_r + 64'sd2147483648) >>> 32;
          default:                 acc_nxt = acc_r;
        endcase
      end
      rsmfl_pkg::OP_OUT: begin
        if (!out_busy) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = bad_r ? rsmfl_pkg::BAD_DIST : dist_sat;
          out_filt_nxt  = held_max_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_break_r  <= rsmfl_pkg::LOW_BREAK_RST;
      high_break_r <= rsmfl_pkg::HIGH_BREAK_RST;
      slot_r       <= '0;
      fill_r       <= '0;
      held_max_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      low_break_r  <= low_break_nxt;
      high_break_r <= high_break_nxt;
      slot_r       <= slot_nxt;
      fill_r       <= fill_nxt;
      held_max_r   <= held_max_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // The ring is only scanned once every slot has been written.
  always_ff @(posedge clk) begin
    if (accept && in_frame_ok) begin
      ring_r[slot_r] <= in_raw_count;
    end
    bad_r      <= bad_nxt;
    scan_idx_r <= scan_idx_nxt;
    scan_max_r <= scan_max_nxt;
    poly_r     <= poly_nxt;
    k_r        <= k_nxt;
    acc_r      <= acc_nxt;
    prod_r     <= prod_nxt;
    out_dist_r <= out_dist_nxt;
    out_filt_r <= out_filt_nxt;
  end

endmodule
`default_nettype wire

@@ rtl/range_sensor_max_filter_linearizer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// range_sensor_max_filter_linearizer: max filter and count-to-cm conversion
// Each input transfer carries one sensor count and a frame-ok flag; each
// yields one output transfer with the distance (signed Q12 cm) and the
// filtered count. Valid counts enter a WINDOW-deep ring; once it is full the
// filtered count is the ring maximum, found by a scan of one slot per cycle.
// The distance comes from a piecewise polynomial evaluated by Horner's rule
// on one 32x16 multiplier, with low-word and high-word multiplies and an add per
// coefficient, under a microcode sequencer. A bad frame answers -1 cm. The
// ring is scanned only when it is full; the polynomial is cubic, quintic or
// quadratic (degree 3, 5 or 2). The next item is taken once the result is
// registered and the sequencer is back in its idle step. A stalled receiver
// holds the result in the output register and the sequencer waits on its
// final step. Reset clears the ring pointer and fill count, the filtered
// count and the output valid flag, and loads the break registers with 506
// and 1253. The configuration port is always ready and is to be written
// only while the block is idle, which the block itself does not enforce.
// ---------------------------------------------------------------------------
module range_sensor_max_filter_linearizer #(
  parameter int WINDOW = rsmfl_pkg::WINDOW_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid,
  output wire logic                                cfg_ready,
  input  wire logic [rsmfl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [rsmfl_pkg::COUNT_W-1:0]       cfg_data,
  input  wire logic                                in_valid,
  output wire logic                                in_ready,
  input  wire logic [rsmfl_pkg::COUNT_W-1:0]       in_raw_count,
  input  wire logic                                in_frame_ok,
  output wire logic                                out_valid,
  input  wire logic                                out_ready,
  output wire logic signed [rsmfl_pkg::DIST_W-1:0] out_distance_cm,
  output wire logic [rsmfl_pkg::COUNT_W-1:0]       out_filtered_count
);

  rsmfl_pkg::ctrl_t ctrl;
  rsmfl_pkg::stat_t stat;

  rsmfl_useq u_useq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctrl  (ctrl)
  );

  rsmfl_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctrl               (ctrl),
    .stat               (stat),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_count       (in_raw_count),
    .in_frame_ok        (in_frame_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance_cm    (out_distance_cm),
    .out_filtered_count (out_filtered_count)
  );

endmodule
`default_nettype wire

@@ bench/range_sensor_max_filter_linearizer_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_sensor_max_filter_linearizer_checker: result predictor and comparator
// Watches the configuration, input and result channels of the range sensor
// filter. Every input transfer queues the distance and filtered count the
// block must answer; a valid one first updates a private max filter copy.
// Each result is compared field by field with the oldest queued answer.
// ---------------------------------------------------------------------------
module range_sensor_max_filter_linearizer_checker
  import rsmfl_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [COUNT_W-1:0]        cfg_data,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [COUNT_W-1:0]        in_raw_count,
  input  logic                      in_frame_ok,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic signed [DIST_W-1:0]  out_distance_cm,
  input  logic [COUNT_W-1:0]        out_filtered_count,
  output int unsigned               fail_count,
  output int unsigned               results_due
);

  localparam int FILTER_DEPTH = WINDOW_DEF;
  localparam logic signed [DIST_W-1:0] BAD_FRAME_CM = -32'sd4096;
  localparam logic signed [63:0] Q12_MAX = 64'sd2147483647;
  localparam logic signed [63:0] Q12_MIN = -64'sd2147483648;

  typedef struct packed {
    logic signed [DIST_W-1:0] distance_cm;
    logic [COUNT_W-1:0]       filtered_count;
  } reading_t;

  reading_t due_q[$];

  logic [COUNT_W-1:0] low_break_q;
  logic [COUNT_W-1:0] high_break_q;
  logic [COUNT_W-1:0] count_ring [FILTER_DEPTH];
  int unsigned        ring_slot;
  int unsigned        ring_fill;
  logic [COUNT_W-1:0] peak_count;
  int unsigned        mismatches = 0;

  // Fixed-point Horner coefficients, indexed by polynomial and power of f.
  logic signed [63:0] horner_coef [3][6];

  function automatic int horner_degree(poly_t p);
    case (p)
      POLY_QUINTIC: return 5;
      POLY_QUAD:    return 2;
      default:      return 3;
    endcase
  endfunction

  // Binary scale of the final accumulator for each polynomial.
  function automatic int horner_scale(poly_t p);
    case (p)
      POLY_QUINTIC: return 20;
      POLY_QUAD:    return 44;
      default:      return 24;
    endcase
  endfunction

  // mant * 10^-dec * 2^shift, rounded to nearest with ties away from zero.
  function automatic logic signed [63:0] scaled_coef(logic [63:0] mant, int dec, bit neg,
                                                     int shift);
    logic [191:0] num;
    logic [191:0] den;
    logic [191:0] quot;
    logic [63:0]  half_up;
    den = 192'd1;
    for (int i = 0; i < dec; i++) den = den * 192'd10;
    num = {128'd0, mant} << (shift + 1);
    quot = num / den;
    half_up = (quot[63:0] + 64'd1) >> 1;
    return neg ? -$signed(half_up) : $signed(half_up);
  endfunction

  task automatic set_coef(poly_t p, int j, logic [63:0] mant, int dec, bit neg);
    int n;
    n = horner_degree(p);
    horner_coef[p][j] = scaled_coef(mant, dec, neg,
                                    horner_scale(p) + 16 * ((j < n) ? j : n - 1));
  endtask

  initial begin
    set_coef(POLY_CUBIC, 3, 64'd12023716293, 14, 1'b1);
    set_coef(POLY_CUBIC, 2, 64'd17212411657, 11, 1'b0);
    set_coef(POLY_CUBIC, 1, 64'd82796230077, 9, 1'b1);
    set_coef(POLY_CUBIC, 0, 64'd13500, 0, 1'b0);
    set_coef(POLY_QUINTIC, 5, 64'd16303911361, 22, 1'b1);
    set_coef(POLY_QUINTIC, 4, 64'd79593173713, 19, 1'b0);
    set_coef(POLY_QUINTIC, 3, 64'd15477757333, 15, 1'b1);
    set_coef(POLY_QUINTIC, 2, 64'd1505512676, 11, 1'b0);
    set_coef(POLY_QUINTIC, 1, 64'd74075664630, 10, 1'b1);
    set_coef(POLY_QUINTIC, 0, 64'd1530511, 3, 1'b0);
    set_coef(POLY_QUAD, 2, 64'd16913557022, 15, 1'b1);
    set_coef(POLY_QUAD, 1, 64'd39972587192, 12, 1'b0);
    set_coef(POLY_QUAD, 0, 64'd34762, 4, 1'b1);
  end

  function automatic logic signed [DIST_W-1:0] count_to_cm(poly_t p, logic [COUNT_W-1:0] f);
    logic signed [63:0] acc;
    logic signed [63:0] f_wide;
    int n;
    int s1;
    n = horner_degree(p);
    s1 = horner_scale(p);
    f_wide = $signed({48'd0, f});
    acc = horner_coef[p][n];
    for (int j = n - 1; j >= 0; j--) begin
      acc = acc * f_wide + horner_coef[p][j];
      // Arithmetic shift on a signed value rounds toward minus infinity.
      if (j > 0) acc = acc >>> 16;
    end
    acc = (acc + (64'sd1 <<< (s1 - 13))) >>> (s1 - 12);
    if (acc > Q12_MAX) return Q12_MAX[DIST_W-1:0];
    if (acc < Q12_MIN) return Q12_MIN[DIST_W-1:0];
    return acc[DIST_W-1:0];
  endfunction

  // Applies one input transfer to the filter copy and returns its answer.
  function automatic reading_t take_reading(logic [COUNT_W-1:0] raw, logic ok);
    reading_t    ans;
    poly_t       branch;
    logic [COUNT_W-1:0] top;
    if (!ok) begin
      ans.distance_cm = BAD_FRAME_CM;
      ans.filtered_count = peak_count;
      return ans;
    end
    if (ring_slot >= FILTER_DEPTH) ring_slot = 0;
    count_ring[ring_slot] = raw;
    ring_slot = (ring_slot + 1 >= FILTER_DEPTH) ? 0 : ring_slot + 1;
    if (ring_fill < FILTER_DEPTH) ring_fill++;
    if (ring_fill >= FILTER_DEPTH) begin
      top = '0;
      for (int i = 0; i < FILTER_DEPTH; i++)
        if (count_ring[i] > top) top = count_ring[i];
      peak_count = top;
    end
    // The cubic test wins even when the breaks are given in reverse order.
    if (peak_count < low_break_q) branch = POLY_CUBIC;
    else if (peak_count > high_break_q) branch = POLY_QUAD;
    else branch = POLY_QUINTIC;
    ans.distance_cm = count_to_cm(branch, peak_count);
    ans.filtered_count = peak_count;
    return ans;
  endfunction

  always @(posedge clk) begin
    reading_t want;
    if (!rst_n) begin
      low_break_q = 16'd506;
      high_break_q = 16'd1253;
      for (int i = 0; i < FILTER_DEPTH; i++) count_ring[i] = '0;
      ring_slot = 0;
      ring_fill = 0;
      peak_count = '0;
      due_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_LOW_BREAK:  low_break_q = cfg_data;
          REG_HIGH_BREAK: high_break_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) due_q.push_back(take_reading(in_raw_count, in_frame_ok));
      if (out_valid && out_ready) begin
        if (due_q.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result, actual distance_cm %0d filtered_count %0d",
                   $time, out_distance_cm, out_filtered_count);
        end else begin
          want = due_q.pop_front();
          if (out_distance_cm !== want.distance_cm) begin
            mismatches++;
            $display("%0t: distance_cm mismatch, expected %0d, actual %0d",
                     $time, want.distance_cm, out_distance_cm);
          end
          if (out_filtered_count !== want.filtered_count) begin
            mismatches++;
            $display("%0t: filtered_count mismatch, expected %0d, actual %0d",
                     $time, want.filtered_count, out_filtered_count);
          end
        end
      end
    end
    results_due <= due_q.size();
    fail_count <= mismatches;
  end

endmodule

@@ bench/range_sensor_max_filter_linearizer_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// range_sensor_max_filter_linearizer_test: top-level bench of the range filter
// Drives directed and random sensor readings through several break register
// settings, with bursty input, an irregular result consumer and one long
// consumer stall. A checker beside the block predicts and compares results.
// ---------------------------------------------------------------------------
module range_sensor_max_filter_linearizer_test;
  import rsmfl_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 4'd15;
  localparam int IDLE_LIMIT  = 3000;
  localparam int LONG_STALL  = 600;
  localparam int DRAIN_GUARD = 30;

  logic                     clk;
  logic                     rst_n = 1'b0;
  logic                     cfg_valid = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = '0;
  logic [COUNT_W-1:0]       cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic [COUNT_W-1:0]       in_raw_count = '0;
  logic                     in_frame_ok = 1'b0;
  logic                     out_ready = 1'b0;
  wire                      cfg_ready;
  wire                      in_ready;
  wire                      out_valid;
  wire signed [DIST_W-1:0]  out_distance_cm;
  wire [COUNT_W-1:0]        out_filtered_count;
  int unsigned              fail_count;
  int unsigned              results_due;

  logic [COUNT_W-1:0] cur_low = 16'd506;
  logic [COUNT_W-1:0] cur_high = 16'd1253;
  int                 burst_left = 0;
  logic               long_stall_req = 1'b0;
  int                 idle_cycles = 0;

  range_sensor_max_filter_linearizer u_top (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_count       (in_raw_count),
    .in_frame_ok        (in_frame_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance_cm    (out_distance_cm),
    .out_filtered_count (out_filtered_count)
  );

  range_sensor_max_filter_linearizer_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_raw_count       (in_raw_count),
    .in_frame_ok        (in_frame_ok),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_distance_cm    (out_distance_cm),
    .out_filtered_count (out_filtered_count),
    .fail_count         (fail_count),
    .results_due        (results_due)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Result consumer: stretches of steady, random or sparse acceptance, and
  // one long hold-off so that the block backs up into its input.
  initial begin
    int mode;
    int span;
    logic long_stall_done;
    long_stall_done = 1'b0;
    forever begin
      if (long_stall_req && !long_stall_done) begin
        long_stall_done = 1'b1;
        repeat (LONG_STALL) begin
          @(posedge clk);
          out_ready <= 1'b0;
        end
      end
      mode = $urandom_range(0, 2);
      span = $urandom_range(20, 80);
      repeat (span) begin
        @(posedge clk);
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  task automatic send_reading(logic [COUNT_W-1:0] cnt, logic ok);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    in_raw_count <= cnt;
    in_frame_ok <= ok;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Stops the input and waits until every queued answer has come back.
  task automatic settle();
    in_valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (results_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_LOW_BREAK) cur_low = val;
    if (idx == REG_HIGH_BREAK) cur_high = val;
    @(posedge clk);
  endtask

  function automatic logic [COUNT_W-1:0] near_value(logic [COUNT_W-1:0] center);
    int v;
    v = int'(center) + int'($urandom_range(0, 4)) - 2;
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v[COUNT_W-1:0];
  endfunction

  function automatic logic [COUNT_W-1:0] pick_count();
    case ($urandom_range(0, 5))
      0:       return COUNT_W'($urandom_range(0, 65535));
      1:       return COUNT_W'($urandom_range(0, 2047));
      2:       return near_value(cur_low);
      3:       return near_value(cur_high);
      4:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return COUNT_W'($urandom_range(0, 15));
    endcase
  endfunction

  // Random readings; a repeated count with all frames good fills the window
  // so the filtered value lands exactly on the chosen count.
  task automatic run_random(int total);
    int sent;
    int reps;
    logic [COUNT_W-1:0] cnt;
    sent = 0;
    while (sent < total) begin
      cnt = pick_count();
      reps = ($urandom_range(0, 3) == 0) ? 3 : 1;
      repeat (reps) begin
        send_reading(cnt, $urandom_range(0, 7) != 0);
        sent++;
      end
    end
  endtask

  initial begin
    logic [COUNT_W-1:0] edge_counts [5];
    logic [COUNT_W-1:0] brk_a;
    logic [COUNT_W-1:0] brk_b;
    edge_counts = '{16'd505, 16'd506, 16'd1253, 16'd1254, 16'd0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Reset breaks: a bad frame first, then readings before the window fills.
    send_reading(16'hFFFF, 1'b0);
    send_reading(16'h0000, 1'b1);
    send_reading(16'hFFFF, 1'b1);
    send_reading(16'd1234, 1'b1);
    send_reading(16'h0000, 1'b0);
    foreach (edge_counts[i])
      repeat (3) send_reading(edge_counts[i], 1'b1);
    run_random(100);

    settle();
    write_reg(REG_LOW_BREAK, 16'd0);
    write_reg(REG_HIGH_BREAK, 16'd0);
    long_stall_req <= 1'b1;
    run_random(100);

    settle();
    write_reg(REG_LOW_BREAK, 16'hFFFF);
    write_reg(REG_HIGH_BREAK, 16'hFFFF);
    run_random(95);

    settle();
    write_reg(REG_LOW_BREAK, 16'd0);
    write_reg(REG_HIGH_BREAK, 16'hFFFF);
    run_random(95);

    // Breaks in reverse order.
    settle();
    write_reg(REG_LOW_BREAK, 16'hFFFF);
    write_reg(REG_HIGH_BREAK, 16'd0);
    run_random(95);

    settle();
    brk_a = COUNT_W'($urandom_range(0, 65535));
    brk_b = COUNT_W'($urandom_range(0, 65535));
    write_reg(REG_LOW_BREAK, (brk_a < brk_b) ? brk_a : brk_b);
    write_reg(REG_HIGH_BREAK, (brk_a < brk_b) ? brk_b : brk_a);
    run_random(95);

    // A write to an unmapped index must leave both breaks alone.
    settle();
    write_reg(REG_LOW_BREAK, 16'd506);
    write_reg(REG_HIGH_BREAK, 16'd1253);
    write_reg(REG_UNMAPPED, 16'h1234);
    run_random(95);

    settle();
    repeat (DRAIN_GUARD) @(posedge clk);
    if (fail_count == 0 && results_due == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
